### design/mrmp_pkg.sv
// Shared types, codes and the CRC-16 step for the meter poller.
package mrmp_pkg;

   localparam int SLOTS   = 9;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam int REQ_LEN = 8;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [7:0]  FC_READ  = 8'h03;
   localparam logic [7:0]  BYTE_CNT = 8'h02;
   localparam logic [7:0]  QTY_HI   = 8'h00;
   localparam logic [7:0]  QTY_LO   = 8'h01;
   localparam logic [7:0]  RX_MAX   = 8'hFF;
   localparam logic [7:0]  REPLY_LEN = 8'd7;

   localparam logic [1:0] FUNC_START   = 2'd0;
   localparam logic [1:0] FUNC_BYTE    = 2'd1;
   localparam logic [1:0] FUNC_EOF     = 2'd2;
   localparam logic [1:0] FUNC_TIMEOUT = 2'd3;

   localparam logic [1:0] REG_INITIAL_SLAVE = 2'd0;
   localparam logic [1:0] REG_ADDRESS       = 2'd1;
   localparam logic [1:0] REG_FREQUENCY     = 2'd2;
   localparam logic [1:0] REG_VOLTAGE       = 2'd3;

   localparam logic [7:0]  RST_INITIAL_SLAVE = 8'd0;
   localparam logic [15:0] RST_ADDRESS       = 16'd272;
   localparam logic [15:0] RST_FREQUENCY     = 16'd304;
   localparam logic [15:0] RST_VOLTAGE       = 16'd305;

   localparam logic [1:0] QTY_ADDRESS   = 2'd0;
   localparam logic [1:0] QTY_FREQUENCY = 2'd1;
   localparam logic [1:0] QTY_VOLTAGE   = 2'd2;

   localparam logic ERR_CRC     = 1'b0;
   localparam logic ERR_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_ADDR = 2'd1,
      PH_FREQ = 2'd2,
      PH_VOLT = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_TX     = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      SRC_DATA   = 2'd0,
      SRC_CRC_LO = 2'd1,
      SRC_CRC_HI = 2'd2
   } src_type;

   typedef struct packed {
      kind_type    kind;
      src_type     src;
      logic [7:0]  tx_byte;
      logic [1:0]  quantity;
      logic [15:0] value;
      logic        error_code;
      logic        last;
   } slot_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

### design/modbus_rtu_meter_poller.sv
// Modbus RTU meter poller: request builder, reply checker and result queue.
// The first result of an item shows in the cycle after it is accepted.
// One item per cycle while the result queue is free; an item that makes
// results waits until the queue drains, one result per ready cycle (up to 9).
// Request CRC bytes come from a CRC register updated as each byte leaves.
// Reset (synchronous, active high) clears phase, reception and queue, and
// returns the configuration registers to their defaults.
module modbus_rtu_meter_poller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_tx_byte,
   output logic [1:0]  rsp_quantity,
   output logic [15:0] rsp_value,
   output logic        rsp_error_code,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]  cfg_slave_ff;
   logic [15:0] cfg_addr_ff;
   logic [15:0] cfg_freq_ff;
   logic [15:0] cfg_volt_ff;

   mrmp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  slave_ff, slave_in;
   logic [7:0]  rxcnt_ff, rxcnt_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  hold_ff [2];
   logic [7:0]  hold_in [2];
   logic [7:0]  hdr_ff [4];
   logic [7:0]  hdr_in [4];

   mrmp_pkg::slot_type slots_ff [mrmp_pkg::SLOTS];
   mrmp_pkg::slot_type slots_in [mrmp_pkg::SLOTS];
   mrmp_pkg::slot_type load_slots [mrmp_pkg::SLOTS];
   logic [mrmp_pkg::CNT_W-1:0] count_ff, count_in, load_count;
   logic [15:0] txcrc_ff, txcrc_in;

   logic        busy, accept, pop, load, queue_free;
   logic        send_req, req_after_report;
   logic [15:0] req_reg;
   logic [7:0]  frame [mrmp_pkg::REQ_LEN];
   logic        crc_ok, shape_ok;
   logic        cfg_write;

   // Configuration port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_slave_ff <= mrmp_pkg::RST_INITIAL_SLAVE;
         cfg_addr_ff  <= mrmp_pkg::RST_ADDRESS;
         cfg_freq_ff  <= mrmp_pkg::RST_FREQUENCY;
         cfg_volt_ff  <= mrmp_pkg::RST_VOLTAGE;
      end else if (cfg_write) begin
         case (csr_paddr[3:2])
            mrmp_pkg::REG_INITIAL_SLAVE: cfg_slave_ff <= csr_pwdata[7:0];
            mrmp_pkg::REG_ADDRESS:       cfg_addr_ff  <= csr_pwdata[15:0];
            mrmp_pkg::REG_FREQUENCY:     cfg_freq_ff  <= csr_pwdata[15:0];
            mrmp_pkg::REG_VOLTAGE:       cfg_volt_ff  <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mrmp_pkg::REG_INITIAL_SLAVE: csr_prdata = {24'h0, cfg_slave_ff};
         mrmp_pkg::REG_ADDRESS:       csr_prdata = {16'h0, cfg_addr_ff};
         mrmp_pkg::REG_FREQUENCY:     csr_prdata = {16'h0, cfg_freq_ff};
         mrmp_pkg::REG_VOLTAGE:       csr_prdata = {16'h0, cfg_volt_ff};
         default:                     csr_prdata = 32'h0;
      endcase
   end

   // Handshakes
   assign busy       = (phase_ff != mrmp_pkg::PH_IDLE);
   assign rsp_valid  = (count_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign queue_free = (count_ff == '0) ||
                       ((count_ff == mrmp_pkg::CNT_W'(1)) && rsp_ready);
   assign req_ready  = queue_free || (req_func == mrmp_pkg::FUNC_BYTE) ||
                       (!busy && (req_func != mrmp_pkg::FUNC_START));
   assign accept     = req_valid && req_ready;
   assign load       = accept && (load_count != '0);

   assign crc_ok   = (hold_ff[0] == crc_ff[7:0]) && (hold_ff[1] == crc_ff[15:8]);
   assign shape_ok = (rxcnt_ff == mrmp_pkg::REPLY_LEN) && (hdr_ff[0] == mrmp_pkg::FC_READ) &&
                     (hdr_ff[1] == mrmp_pkg::BYTE_CNT);

   // Next state of the reception and the result plan of the accepted item
   always_comb begin
      phase_in         = phase_ff;
      slave_in         = slave_ff;
      rxcnt_in         = rxcnt_ff;
      crc_in           = crc_ff;
      hold_in          = hold_ff;
      hdr_in           = hdr_ff;
      load_count       = '0;
      send_req         = 1'b0;
      req_after_report = 1'b0;
      req_reg          = cfg_addr_ff;
      for (int i = 0; i < mrmp_pkg::SLOTS; i++) begin
         load_slots[i] = '0;
      end

      if (accept) begin
         if (req_func == mrmp_pkg::FUNC_START) begin
            slave_in   = cfg_slave_ff;
            phase_in   = mrmp_pkg::PH_ADDR;
            send_req   = 1'b1;
            req_reg    = cfg_addr_ff;
            load_count = mrmp_pkg::CNT_W'(mrmp_pkg::REQ_LEN);
         end else if (busy) begin
            case (req_func)
               mrmp_pkg::FUNC_BYTE: begin
                  if (rxcnt_ff >= 8'd2) begin
                     crc_in = mrmp_pkg::crc_feed(crc_ff, hold_ff[0]);
                  end
                  hold_in[0] = hold_ff[1];
                  hold_in[1] = req_rx_byte;
                  case (rxcnt_ff)
                     8'd1:    hdr_in[0] = req_rx_byte;
                     8'd2:    hdr_in[1] = req_rx_byte;
                     8'd3:    hdr_in[2] = req_rx_byte;
                     8'd4:    hdr_in[3] = req_rx_byte;
                     default: ;
                  endcase
                  if (rxcnt_ff != mrmp_pkg::RX_MAX) begin
                     rxcnt_in = rxcnt_ff + 8'd1;
                  end
               end
               mrmp_pkg::FUNC_TIMEOUT: begin
                  phase_in                 = mrmp_pkg::PH_IDLE;
                  load_slots[0].kind       = mrmp_pkg::KIND_ERROR;
                  load_slots[0].error_code = mrmp_pkg::ERR_TIMEOUT;
                  load_count               = mrmp_pkg::CNT_W'(1);
               end
               mrmp_pkg::FUNC_EOF: begin
                  if (rxcnt_ff > 8'd2) begin
                     if (!crc_ok) begin
                        phase_in                 = mrmp_pkg::PH_IDLE;
                        load_slots[0].kind       = mrmp_pkg::KIND_ERROR;
                        load_slots[0].error_code = mrmp_pkg::ERR_CRC;
                        load_count               = mrmp_pkg::CNT_W'(1);
                     end else if (shape_ok) begin
                        load_slots[0].kind  = mrmp_pkg::KIND_REPORT;
                        load_slots[0].value = {hdr_ff[2], hdr_ff[3]};
                        case (phase_ff)
                           mrmp_pkg::PH_ADDR: begin
                              slave_in                = hdr_ff[3];
                              load_slots[0].quantity  = mrmp_pkg::QTY_ADDRESS;
                              phase_in                = mrmp_pkg::PH_FREQ;
                              send_req                = 1'b1;
                              req_after_report        = 1'b1;
                              req_reg                 = cfg_freq_ff;
                              load_count = mrmp_pkg::CNT_W'(mrmp_pkg::REQ_LEN + 1);
                           end
                           mrmp_pkg::PH_FREQ: begin
                              load_slots[0].quantity  = mrmp_pkg::QTY_FREQUENCY;
                              phase_in                = mrmp_pkg::PH_VOLT;
                              send_req                = 1'b1;
                              req_after_report        = 1'b1;
                              req_reg                 = cfg_volt_ff;
                              load_count = mrmp_pkg::CNT_W'(mrmp_pkg::REQ_LEN + 1);
                           end
                           default: begin
                              load_slots[0].quantity = mrmp_pkg::QTY_VOLTAGE;
                              load_slots[1].kind     = mrmp_pkg::KIND_DONE;
                              phase_in               = mrmp_pkg::PH_IDLE;
                              load_count             = mrmp_pkg::CNT_W'(2);
                           end
                        endcase
                     end
                  end
               end
               default: ;
            endcase
         end

         if ((req_func != mrmp_pkg::FUNC_BYTE) && (busy || (req_func == mrmp_pkg::FUNC_START)))
         begin
            rxcnt_in = '0;
            crc_in   = mrmp_pkg::CRC_INIT;
            hold_in  = '{default: '0};
            hdr_in   = '{default: '0};
         end
      end

      frame[0] = slave_in;
      frame[1] = mrmp_pkg::FC_READ;
      frame[2] = req_reg[15:8];
      frame[3] = req_reg[7:0];
      frame[4] = mrmp_pkg::QTY_HI;
      frame[5] = mrmp_pkg::QTY_LO;
      frame[6] = 8'h00;
      frame[7] = 8'h00;

      if (send_req) begin
         for (int i = 0; i < mrmp_pkg::REQ_LEN; i++) begin
            if (req_after_report) begin
               load_slots[i+1].kind    = mrmp_pkg::KIND_TX;
               load_slots[i+1].tx_byte = frame[i];
               load_slots[i+1].src     = (i == mrmp_pkg::REQ_LEN - 2) ? mrmp_pkg::SRC_CRC_LO :
                                         (i == mrmp_pkg::REQ_LEN - 1) ? mrmp_pkg::SRC_CRC_HI :
                                                                        mrmp_pkg::SRC_DATA;
            end else begin
               load_slots[i].kind    = mrmp_pkg::KIND_TX;
               load_slots[i].tx_byte = frame[i];
               load_slots[i].src     = (i == mrmp_pkg::REQ_LEN - 2) ? mrmp_pkg::SRC_CRC_LO :
                                       (i == mrmp_pkg::REQ_LEN - 1) ? mrmp_pkg::SRC_CRC_HI :
                                                                      mrmp_pkg::SRC_DATA;
            end
         end
      end

      for (int i = 0; i < mrmp_pkg::SLOTS; i++) begin
         load_slots[i].last = (mrmp_pkg::CNT_W'(i + 1) == load_count);
      end
   end

   // Result queue: load a plan, shift out one result per cycle with rsp_ready
   always_comb begin
      slots_in = slots_ff;
      count_in = count_ff;
      txcrc_in = txcrc_ff;
      if (pop) begin
         for (int i = 0; i < mrmp_pkg::SLOTS - 1; i++) begin
            slots_in[i] = slots_ff[i+1];
         end
         slots_in[mrmp_pkg::SLOTS-1] = '0;
         count_in = count_ff - mrmp_pkg::CNT_W'(1);
         if (slots_ff[0].kind == mrmp_pkg::KIND_TX) begin
            case (slots_ff[0].src)
               mrmp_pkg::SRC_DATA:   txcrc_in = mrmp_pkg::crc_feed(txcrc_ff, slots_ff[0].tx_byte);
               mrmp_pkg::SRC_CRC_HI: txcrc_in = mrmp_pkg::CRC_INIT;
               default: ;
            endcase
         end
      end
      if (load) begin
         slots_in = load_slots;
         count_in = load_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mrmp_pkg::PH_IDLE;
         slave_ff <= mrmp_pkg::RST_INITIAL_SLAVE;
         rxcnt_ff <= '0;
         crc_ff   <= mrmp_pkg::CRC_INIT;
         hold_ff  <= '{default: '0};
         hdr_ff   <= '{default: '0};
         slots_ff <= '{default: '0};
         count_ff <= '0;
         txcrc_ff <= mrmp_pkg::CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         slave_ff <= slave_in;
         rxcnt_ff <= rxcnt_in;
         crc_ff   <= crc_in;
         hold_ff  <= hold_in;
         hdr_ff   <= hdr_in;
         slots_ff <= slots_in;
         count_ff <= count_in;
         txcrc_ff <= txcrc_in;
      end
   end

   assign rsp_kind       = slots_ff[0].kind;
   assign rsp_tx_byte    = (slots_ff[0].src == mrmp_pkg::SRC_CRC_LO) ? txcrc_ff[7:0] :
                           (slots_ff[0].src == mrmp_pkg::SRC_CRC_HI) ? txcrc_ff[15:8] :
                                                                       slots_ff[0].tx_byte;
   assign rsp_quantity   = slots_ff[0].quantity;
   assign rsp_value      = slots_ff[0].value;
   assign rsp_error_code = slots_ff[0].error_code;
   assign rsp_last       = slots_ff[0].last;

   a_last_on_final: assert property (@(posedge clock) disable iff (reset)
      (count_ff == mrmp_pkg::CNT_W'(1)) |-> slots_ff[0].last)
      else $error("final queued result lacks last");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> ((count_ff == '0) || ((count_ff == mrmp_pkg::CNT_W'(1)) && pop)))
      else $error("result plan loaded over pending results");

   a_txcrc_idle: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (txcrc_ff == mrmp_pkg::CRC_INIT))
      else $error("transmit CRC not reinitialized between frames");

endmodule
